// File: design/tcp_byte_stream_reassembler_top_defines.svh
// Assertion macros for the stream reassembler.
// Used at the end of tcp_byte_stream_reassembler_top; expects clk_i and rst_ni in scope.
`ifndef TCP_BYTE_STREAM_REASSEMBLER_TOP_DEFINES_SVH
`define TCP_BYTE_STREAM_REASSEMBLER_TOP_DEFINES_SVH

// same-cycle implication
`define TBSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tbsr_pkg.sv
// Shared constants and types for the stream reassembler.
// No dependencies.
`default_nettype none

package tbsr_pkg;

  localparam int WIN_AW       = 6;
  localparam int WINDOW_BYTES = 1 << WIN_AW;
  localparam int CNT_W        = WIN_AW + 1;
  localparam int IDX_W        = 64;
  localparam int ROOM_W       = 7;

  typedef struct packed {
    logic invert_b;
    logic carry_in;
  } alu_op_t;

  typedef struct packed {
    logic              wr_en;
    logic [WIN_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_addr;
    logic [WIN_AW-1:0] chk_addr;
  } win_ctrl_t;

endpackage

`default_nettype wire

// File: design/tbsr_alu.sv
// Shared 64-bit add/subtract unit for the stream reassembler.
// Depends on tbsr_pkg.
`default_nettype none

module tbsr_alu
  import tbsr_pkg::*;
(
  input  wire logic [IDX_W-1:0] a_i,
  input  wire logic [IDX_W-1:0] b_i,
  input  wire alu_op_t          op_i,
  output logic      [IDX_W-1:0] sum_o,
  output logic                  cout_o
);

  logic [IDX_W-1:0] b_sel;
  logic [IDX_W:0]   full;

  always_comb begin
    b_sel  = op_i.invert_b ? ~b_i : b_i;
    full   = {1'b0, a_i} + {1'b0, b_sel} + {{IDX_W{1'b0}}, op_i.carry_in};
    sum_o  = full[IDX_W-1:0];
    cout_o = full[IDX_W];
  end

endmodule

`default_nettype wire

// File: design/tbsr_window.sv
// Circular window store with per-slot valid marks.
// Depends on tbsr_pkg.
`default_nettype none

module tbsr_window
  import tbsr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire win_ctrl_t ctrl_i,
  output logic [7:0]     rd_data_o,
  output logic           chk_valid_o
);

  logic [7:0]              mem_q [WINDOW_BYTES];
  logic [7:0]              rd_data_q;
  logic [WINDOW_BYTES-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[ctrl_i.rd_addr];
    end
  end

  // reading a slot releases it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[ctrl_i.wr_addr] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        valid_q[ctrl_i.rd_addr] <= 1'b0;
      end
    end
  end

  assign rd_data_o   = rd_data_q;
  assign chk_valid_o = valid_q[ctrl_i.chk_addr];

endmodule

`default_nettype wire

// File: design/tcp_byte_stream_reassembler_top.sv
// Top level of the byte stream reassembler: sequencer, stream state, result port.
// Depends on tbsr_pkg, tbsr_alu, tbsr_window and the assertion macro header.
//
// Usage: drive one request (one stream byte, or an empty substring) on the
// input ports with start high; it is taken at the edge where busy is low.
// busy stays high while the request is worked on. Each result appears for one
// cycle with res_stb_o high; the receiver cannot hold it off. A request gives
// one result per released in-order byte (out_valid_o high), or a single status
// result (out_valid_o low, out_byte_o zero) when nothing is released.
// run_last_o marks the last result of a request; stream_closed_o and
// pending_bytes_o carry the state after the whole request on every result.
// A closed stream goes straight to its status result. Otherwise the single 64-bit
// add/subtract unit is used once each for the window check, the end index, the
// pushed count and the close compare, the run scan checks one valid mark per
// cycle, and the single read port of the window memory gives one byte per cycle.
// busy falls in the cycle of the last strobe, so the next request can be taken
// at the edge that ends it.
// Reset clears the valid marks, pushed count, end marking, closed flag and
// pending count at once; there is no clearing pass.
`include "tcp_byte_stream_reassembler_top_defines.svh"
`default_nettype none

module tcp_byte_stream_reassembler_top
  import tbsr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [IDX_W-1:0]  byte_index_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              no_byte_i,
  input  wire logic              segment_end_i,
  input  wire logic              final_substring_i,
  input  wire logic [ROOM_W-1:0] writer_room_i,
  output logic                   res_stb_o,
  output logic                   out_valid_o,
  output logic [7:0]             out_byte_o,
  output logic                   run_last_o,
  output logic                   stream_closed_o,
  output logic [ROOM_W-1:0]      pending_bytes_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OFS   = 3'd1;
  localparam logic [2:0] S_END   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CALC  = 3'd4;
  localparam logic [2:0] S_CLOSE = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_STAT  = 3'd7;

  localparam logic [CNT_W-1:0]  WIN_CNT  = CNT_W'(WINDOW_BYTES);
  localparam logic [ROOM_W-1:0] WIN_ROOM = ROOM_W'(WINDOW_BYTES);

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  pushed_q, pushed_d;
  logic [IDX_W-1:0]  end_q, end_d;
  logic              end_known_q, end_known_d;
  logic              closed_q, closed_d;
  logic [ROOM_W-1:0] pending_q, pending_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WIN_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic              emit_q, emit_d;
  logic              emit_byte_q, emit_byte_d;
  logic              last_q, last_d;

  logic [IDX_W-1:0]  idx_q;
  logic [7:0]        byte_q;
  logic              nob_q;
  logic              mark_q;
  logic [ROOM_W-1:0] room_q;

  logic [IDX_W-1:0]  alu_a, alu_b, alu_sum;
  alu_op_t           alu_op;
  logic              alu_cout;

  win_ctrl_t         win_ctrl;
  logic [7:0]        win_rd_data;
  logic              win_chk_valid;

  logic              in_win;
  logic [WIN_AW-1:0] scan_slot;

  tbsr_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .op_i   (alu_op),
    .sum_o  (alu_sum),
    .cout_o (alu_cout)
  );

  tbsr_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (win_ctrl),
    .rd_data_o   (win_rd_data),
    .chk_valid_o (win_chk_valid)
  );

  assign scan_slot = pushed_q[WIN_AW-1:0] + cnt_q[WIN_AW-1:0];
  assign in_win    = !nob_q && (alu_sum[IDX_W-1:ROOM_W] == '0) &&
                     (alu_sum[ROOM_W-1:0] < room_q);

  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = '{invert_b: 1'b0, carry_in: 1'b0};
    unique case (state_q)
      S_OFS: begin
        alu_a  = idx_q;
        alu_b  = pushed_q;
        alu_op = '{invert_b: 1'b1, carry_in: 1'b1};
      end
      S_END: begin
        alu_a  = idx_q;
        alu_op = '{invert_b: 1'b0, carry_in: !nob_q};
      end
      S_CALC: begin
        alu_a = pushed_q;
        alu_b = IDX_W'(cnt_q);
      end
      S_CLOSE: begin
        alu_a  = pushed_q;
        alu_b  = end_q;
        alu_op = '{invert_b: 1'b1, carry_in: 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pushed_d    = pushed_q;
    end_d       = end_q;
    end_known_d = end_known_q;
    closed_d    = closed_q;
    pending_d   = pending_q;
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    emit_d      = 1'b0;
    emit_byte_d = emit_byte_q;
    last_d      = last_q;
    win_ctrl    = '{wr_en: 1'b0, wr_addr: idx_q[WIN_AW-1:0], wr_data: byte_q,
                    rd_en: 1'b0, rd_addr: rd_ptr_q, chk_addr: idx_q[WIN_AW-1:0]};
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = closed_q ? S_STAT : S_OFS;
        end
      end
      S_OFS: begin
        if (in_win) begin
          win_ctrl.wr_en = 1'b1;
          if (!win_chk_valid) begin
            pending_d = pending_q + ROOM_W'(1);
          end
        end
        state_d = S_END;
      end
      S_END: begin
        if (mark_q) begin
          end_d       = (alu_cout && !nob_q) ? '1 : alu_sum;
          end_known_d = 1'b1;
        end
        cnt_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        win_ctrl.chk_addr = scan_slot;
        if ((cnt_q < WIN_CNT) && win_chk_valid) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        pushed_d  = alu_sum;
        pending_d = pending_q - ROOM_W'(cnt_q);
        rd_ptr_d  = pushed_q[WIN_AW-1:0];
        state_d   = S_CLOSE;
      end
      S_CLOSE: begin
        closed_d = end_known_q && alu_cout;
        state_d  = (cnt_q == '0) ? S_STAT : S_DRAIN;
      end
      S_DRAIN: begin
        win_ctrl.rd_en = 1'b1;
        rd_ptr_d       = rd_ptr_q + WIN_AW'(1);
        cnt_d          = cnt_q - CNT_W'(1);
        emit_d         = 1'b1;
        emit_byte_d    = 1'b1;
        last_d         = (cnt_q == CNT_W'(1));
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      S_STAT: begin
        emit_d      = 1'b1;
        emit_byte_d = 1'b0;
        last_d      = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pushed_q    <= '0;
      end_q       <= '0;
      end_known_q <= 1'b0;
      closed_q    <= 1'b0;
      pending_q   <= '0;
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      emit_q      <= 1'b0;
      emit_byte_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      pushed_q    <= pushed_d;
      end_q       <= end_d;
      end_known_q <= end_known_d;
      closed_q    <= closed_d;
      pending_q   <= pending_d;
      cnt_q       <= cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      emit_q      <= emit_d;
      emit_byte_q <= emit_byte_d;
      last_q      <= last_d;
    end
  end

  // request capture; room capped at the window size
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      idx_q  <= byte_index_i;
      byte_q <= data_byte_i;
      nob_q  <= no_byte_i;
      mark_q <= final_substring_i && (segment_end_i || no_byte_i);
      room_q <= (writer_room_i > WIN_ROOM) ? WIN_ROOM : writer_room_i;
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign res_stb_o       = emit_q;
  assign out_valid_o     = emit_byte_q;
  assign out_byte_o      = emit_byte_q ? win_rd_data : 8'd0;
  assign run_last_o      = last_q;
  assign stream_closed_o = closed_q;
  assign pending_bytes_o = pending_q;

  `TBSR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `TBSR_ASSERT_NOW(a_last_idle, res_stb_o && run_last_o, !busy, "busy after last result")
  `TBSR_ASSERT_NOW(a_status_last, res_stb_o && !out_valid_o, run_last_o,
                   "status result not last")
  `TBSR_ASSERT_NEXT(a_closed_sticky, closed_q, closed_q, "closed flag dropped")
  `TBSR_ASSERT_NOW(a_pending_max, 1'b1, pending_q <= WIN_ROOM, "pending count above window")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for tcp_byte_stream_reassembler_top: sends stream bytes and checks every result
// against a behavioral reassembler kept in the testbench. Depends on tbsr_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import tbsr_pkg::*;

  typedef struct packed {
    logic              valid;
    logic [7:0]        data;
    logic              last;
    logic              closed;
    logic [ROOM_W-1:0] pending;
  } result_t;

  localparam int EXP_DEPTH = 256;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [IDX_W-1:0]  byte_index = '0;
  logic [7:0]        data_byte = '0;
  logic              no_byte = 1'b0;
  logic              segment_end = 1'b0;
  logic              final_substring = 1'b0;
  logic [ROOM_W-1:0] writer_room = '0;
  logic              res_stb;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic              run_last;
  logic              stream_closed;
  logic [ROOM_W-1:0] pending_bytes;

  // reassembler state
  logic [7:0]        win_byte [WINDOW_BYTES];
  logic              win_mark [WINDOW_BYTES];
  logic [IDX_W-1:0]  pushed_cnt;
  logic              end_known;
  logic [IDX_W-1:0]  end_pos;
  logic              stream_done;
  logic [ROOM_W-1:0] pending_cnt;

  // expected results, circular
  result_t exp_mem [EXP_DEPTH];
  int      exp_wr = 0;
  int      exp_rd = 0;
  int      mismatch_cnt = 0;
  int      idle_pct = 0;

  tcp_byte_stream_reassembler_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .byte_index_i      (byte_index),
    .data_byte_i       (data_byte),
    .no_byte_i         (no_byte),
    .segment_end_i     (segment_end),
    .final_substring_i (final_substring),
    .writer_room_i     (writer_room),
    .res_stb_o         (res_stb),
    .out_valid_o       (out_valid),
    .out_byte_o        (out_byte),
    .run_last_o        (run_last),
    .stream_closed_o   (stream_closed),
    .pending_bytes_o   (pending_bytes)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic reset_reassembly();
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      win_byte[i] = '0;
      win_mark[i] = 1'b0;
    end
    pushed_cnt  = '0;
    end_known   = 1'b0;
    end_pos     = '0;
    stream_done = 1'b0;
    pending_cnt = '0;
  endtask

  task automatic add_expected(input result_t res);
    exp_mem[exp_wr % EXP_DEPTH] = res;
    exp_wr++;
  endtask

  // Applies one accepted request and queues its results, a status result when nothing is released.
  task automatic predict_reassembly(input logic [IDX_W-1:0] idx, input logic [7:0] data,
                                    input logic empty, input logic seg_end, input logic fin,
                                    input logic [ROOM_W-1:0] room_in);
    logic [IDX_W-1:0]  room;
    logic [IDX_W-1:0]  offset;
    logic [WIN_AW-1:0] slot;
    logic [7:0]        released [WINDOW_BYTES];
    int                n_rel;
    result_t           res;
    n_rel = 0;
    if (!stream_done) begin
      room = (room_in > WINDOW_BYTES) ? IDX_W'(WINDOW_BYTES) : IDX_W'(room_in);
      if (fin && (seg_end || empty)) begin
        if (empty) end_pos = idx;
        else end_pos = (idx == '1) ? idx : idx + 1;
        end_known = 1'b1;
      end
      if (!empty) begin
        offset = idx - pushed_cnt;
        if (offset < room) begin
          slot = idx[WIN_AW-1:0];
          if (!win_mark[slot]) begin
            win_mark[slot] = 1'b1;
            pending_cnt++;
          end
          win_byte[slot] = data;
        end
      end
      while (n_rel < WINDOW_BYTES && win_mark[pushed_cnt[WIN_AW-1:0]]) begin
        slot = pushed_cnt[WIN_AW-1:0];
        released[n_rel] = win_byte[slot];
        n_rel++;
        win_mark[slot] = 1'b0;
        pending_cnt--;
        pushed_cnt++;
      end
      if (end_known && pushed_cnt >= end_pos) stream_done = 1'b1;
    end
    res.closed  = stream_done;
    res.pending = pending_cnt;
    if (n_rel == 0) begin
      res.valid = 1'b0;
      res.data  = '0;
      res.last  = 1'b1;
      add_expected(res);
    end else begin
      for (int k = 0; k < n_rel; k++) begin
        res.valid = 1'b1;
        res.data  = released[k];
        res.last  = (k == n_rel - 1);
        add_expected(res);
      end
    end
  endtask

  task automatic send_request(input logic [IDX_W-1:0] idx, input logic [7:0] data,
                              input logic empty, input logic seg_end, input logic fin,
                              input logic [ROOM_W-1:0] room);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < 20) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    byte_index      = idx;
    data_byte       = data;
    no_byte         = empty;
    segment_end     = seg_end;
    final_substring = fin;
    writer_room     = room;
    start           = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_reassembly(idx, data, empty, seg_end, fin, room);
  endtask

  task automatic stop_requests();
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (exp_wr != exp_rd) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t exp_r;
    if (rst_ni && res_stb) begin
      got = '{out_valid, out_byte, run_last, stream_closed, pending_bytes};
      if (exp_wr == exp_rd) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: valid=%0b byte=%02h last=%0b closed=%0b pending=%0d",
                   got.valid, got.data, got.last, got.closed, got.pending);
      end else begin
        exp_r = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got !== exp_r) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: exp valid=%0b byte=%02h last=%0b closed=%0b pending=%0d",
                     exp_r.valid, exp_r.data, exp_r.last, exp_r.closed, exp_r.pending);
            $display("          got valid=%0b byte=%02h last=%0b closed=%0b pending=%0d",
                     got.valid, got.data, got.last, got.closed, got.pending);
          end
        end
      end
    end
  end

  // window edges, duplicates, room limits, empty substrings, end markings
  task automatic test_directed_edges();
    send_request(64'd0, 8'hFF, 1'b0, 1'b1, 1'b0, 7'd64);
    send_request(64'd2, 8'h00, 1'b0, 1'b0, 1'b0, 7'd64);
    send_request(64'd3, 8'h5A, 1'b0, 1'b1, 1'b0, 7'd64);
    send_request(64'd3, 8'hA5, 1'b0, 1'b0, 1'b0, 7'd64);
    send_request(64'd1, 8'h3C, 1'b0, 1'b0, 1'b0, 7'd1);
    send_request(64'd0, 8'h77, 1'b0, 1'b0, 1'b0, 7'd64);
    send_request(64'd68, 8'h12, 1'b0, 1'b0, 1'b0, 7'd64);
    send_request(64'd67, 8'h11, 1'b0, 1'b0, 1'b0, 7'd64);
    send_request(64'd5, 8'h21, 1'b0, 1'b0, 1'b0, 7'd0);
    send_request(64'd5, 8'h22, 1'b0, 1'b1, 1'b0, 7'd2);
    send_request(64'd68, 8'h13, 1'b0, 1'b0, 1'b0, 7'd127);
    send_request(64'd66, 8'h14, 1'b0, 1'b0, 1'b0, 7'd127);
    send_request(64'd4, 8'hFF, 1'b1, 1'b1, 1'b0, 7'd64);
    send_request('1, 8'h99, 1'b0, 1'b1, 1'b1, 7'd64);
    send_request(64'h8000_0000_0000_0000, 8'h55, 1'b1, 1'b0, 1'b1, 7'd64);
    send_request(64'd4, 8'h44, 1'b0, 1'b0, 1'b1, 7'd64);
    send_request(64'hFFFF_FFFF_FFFF_FFFE, 8'h00, 1'b0, 1'b0, 1'b0, 7'd63);
  endtask

  // fill the whole window back to front, then release all of it at once
  task automatic test_full_window();
    logic [IDX_W-1:0] base;
    base = pushed_cnt;
    for (int i = WINDOW_BYTES - 1; i >= 1; i--)
      send_request(base + i, 8'($urandom), 1'b0, 1'($urandom), 1'b0, 7'd64);
    send_request(base, 8'($urandom), 1'b0, 1'b0, 1'b0, 7'd64);
  endtask

  // mostly in-window bytes out of order, some far-off noise
  task automatic test_random_stream(input int count, input int pct);
    int               r;
    int               offset;
    logic [IDX_W-1:0] idx;
    logic             empty;
    logic             fin;
    logic [ROOM_W-1:0] room;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 85) begin
        offset = (r < 65) ? $urandom_range(7) : $urandom_range(WINDOW_BYTES - 1);
        idx    = pushed_cnt + offset;
        room   = ($urandom_range(3) != 0) ? ROOM_W'($urandom_range(WINDOW_BYTES, offset + 1))
                                          : ROOM_W'($urandom_range(WINDOW_BYTES));
        empty  = ($urandom_range(15) == 0);
        send_request(idx, 8'($urandom), empty, 1'($urandom), 1'b0, room);
      end else begin
        idx   = {$urandom(), $urandom()};
        empty = 1'($urandom);
        fin   = 1'($urandom);
        // keep the end far ahead so the stream stays open
        if (fin && !(idx > pushed_cnt + 1000)) fin = 1'b0;
        send_request(idx, 8'($urandom), empty, 1'($urandom), fin,
                     ROOM_W'($urandom_range(WINDOW_BYTES)));
      end
    end
    stop_requests();
    wait_drained();
    repeat (4) @(posedge clk_i);
  endtask

  // end marked by a byte, moved back by an empty final, reached by release
  task automatic test_close_stream();
    logic [IDX_W-1:0] base;
    idle_pct = 33;
    while (pending_cnt != 0)
      send_request(pushed_cnt, 8'($urandom), 1'b0, 1'b0, 1'b0, 7'd64);
    base = pushed_cnt;
    send_request(base + 4, 8'hC4, 1'b0, 1'b1, 1'b1, 7'd64);
    send_request(base + 2, 8'h00, 1'b1, 1'b0, 1'b1, 7'd64);
    send_request(base + 1, 8'hC1, 1'b0, 1'b0, 1'b0, 7'd64);
    send_request(base, 8'hC0, 1'b0, 1'b0, 1'b0, 7'd64);
    // closed: everything ignored
    send_request(base + 2, 8'hC2, 1'b0, 1'b1, 1'b0, 7'd64);
    send_request(64'd0, 8'h00, 1'b1, 1'b0, 1'b1, 7'd0);
    send_request('1, 8'hFF, 1'b0, 1'b1, 1'b1, 7'd127);
  endtask

  initial begin
    reset_reassembly();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    idle_pct = 0;
    test_directed_edges();
    test_full_window();
    test_random_stream(8, 0);
    test_random_stream(8, 57);
    test_random_stream(8, 0);
    test_random_stream(8, 33);
    test_close_stream();

    stop_requests();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && exp_wr == exp_rd) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
